// ===== hdl/free_list_slot_allocator_top_assert.svh =====
// Assertion macros for the slot allocator.
// FLS_ASSERT checks on every rising clock edge outside reset.
// FLS_ASSERT_ANY checks on every rising clock edge, reset included.
`ifndef FREE_LIST_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_LIST_SLOT_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTH
`define FLS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define FLS_ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define FLS_ASSERT(lbl, prop, msg)
`define FLS_ASSERT_ANY(lbl, prop, msg)
`endif

`endif

// ===== hdl/fls_pkg.sv =====
package fls_pkg;

   // Default pool size and fixed field widths
   localparam int POOL_SLOTS_DEF = 1024;
   localparam int SLOT_W         = 10;
   localparam int STATUS_W       = 3;
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 16;

   // Link value that ends the free list
   localparam int FILENULL = 0;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_HEAD_SLOT = 3'd1,
      STATUS_BOUNDS    = 3'd2,
      STATUS_IS_FREE   = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LINK
   } state_type;

endpackage

// ===== hdl/fls_ram.sv =====
module fls_ram #(
   parameter int DEPTH = fls_pkg::POOL_SLOTS_DEF,
   parameter int WIDTH = fls_pkg::SLOT_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import fls_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds its data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/free_list_slot_allocator_top.sv =====
// Channel   Ports                           Payload
// req       req_tvalid/tready/tdata/tuser   tuser: opcode; tdata: slot_index
// rsp       rsp_tvalid/tready/tdata/tuser   tdata: granted_slot; tuser: status
//
// The accept edge reads the link and in-use memories, and the decide
// step then decides, writes back and loads the response. Freeing into
// a list of two or more entries adds a link step, since the link
// memory has one write port and two entries change.
// Reset clears the head, the highest slot and the control state; the
// memories are not cleared. A response stalled on rsp_tready holds the
// block in the decide cycle.
module free_list_slot_allocator_top #(
   parameter int POOL_SLOTS = fls_pkg::POOL_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fls_pkg::REQ_DATA_W-1:0] req_tdata,  // [9:0] slot_index, rest zero
   input  logic                          req_tuser,  // [0] opcode
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fls_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [9:0] granted_slot, rest zero
   output logic [fls_pkg::STATUS_W-1:0]   rsp_tuser   // [2:0] status
);
   import fls_pkg::*;

`include "free_list_slot_allocator_top_assert.svh"

   localparam int SW = $clog2(POOL_SLOTS);
   localparam int CW = (SW > SLOT_W) ? SW : SLOT_W;

   state_type        state_ff, state_in;
   logic [SW-1:0]    free_head_ff, free_head_in;
   logic [SW-1:0]    highest_ff, highest_in;
   opcode_type       op_ff;
   logic [CW-1:0]    slot_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic             req_accept;
   logic [CW-1:0]    req_slot;

   logic             link_we;
   logic [SW-1:0]    link_waddr, link_wdata, link_rdata;
   logic             used_we, used_wdata, used_rdata;
   logic [SW-1:0]    used_waddr;

   logic             rsp_room;
   logic             slot_is_head, slot_over, list_short, pool_full, link_case;
   logic [SW-1:0]    grow_slot, alloc_slot;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_slot   = CW'(req_tdata[SLOT_W-1:0]);

   // Link memory: next free slot per entry
   fls_ram #(
      .DEPTH(POOL_SLOTS),
      .WIDTH(SW)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (link_we),
      .wr_addr(link_waddr),
      .wr_data(link_wdata),
      .rd_en  (req_accept),
      .rd_addr(free_head_ff),
      .rd_data(link_rdata)
   );

   // In-use memory: one flag per entry
   fls_ram #(
      .DEPTH(POOL_SLOTS),
      .WIDTH(1)
   ) u_used_ram (
      .clock  (clock),
      .wr_en  (used_we),
      .wr_addr(used_waddr),
      .wr_data(used_wdata),
      .rd_en  (req_accept),
      .rd_addr(req_slot[SW-1:0]),
      .rd_data(used_rdata)
   );

   // Decode the held request against the read data
   always_comb begin
      rsp_room     = !rsp_valid_ff || rsp_tready;
      slot_is_head = (slot_ff == '0);
      slot_over    = (slot_ff > CW'(highest_ff));
      list_short   = (free_head_ff == SW'(FILENULL)) || (link_rdata == SW'(FILENULL));
      pool_full    = (highest_ff == SW'(POOL_SLOTS - 1));
      grow_slot    = highest_ff + 1'b1;
      alloc_slot   = (free_head_ff == SW'(FILENULL)) ? grow_slot : free_head_ff;
      link_case    = (op_ff == OP_FREE) && !slot_is_head && !slot_over && used_rdata
                     && !list_short;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (rsp_room) begin
               state_in = link_case ? ST_LINK : ST_IDLE;
            end
         end
         ST_LINK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory writes, head and bound updates, response load
   always_comb begin
      free_head_in  = free_head_ff;
      highest_in    = highest_ff;
      link_we       = 1'b0;
      link_waddr    = slot_ff[SW-1:0];
      link_wdata    = SW'(FILENULL);
      used_we       = 1'b0;
      used_waddr    = slot_ff[SW-1:0];
      used_wdata    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_EXEC: begin
            if (rsp_room) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = '0;
               if (op_ff == OP_ALLOC) begin
                  if ((free_head_ff == SW'(FILENULL)) && pool_full) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     // pop the head or grow the pool
                     if (free_head_ff == SW'(FILENULL)) begin
                        highest_in = grow_slot;
                     end else begin
                        free_head_in = link_rdata;
                     end
                     link_we       = 1'b1;
                     link_waddr    = alloc_slot;
                     link_wdata    = SW'(FILENULL);
                     used_we       = 1'b1;
                     used_waddr    = alloc_slot;
                     used_wdata    = 1'b1;
                     rsp_slot_in   = SLOT_W'(CW'(alloc_slot));
                     rsp_status_in = STATUS_OK;
                  end
               end else if (slot_is_head) begin
                  rsp_status_in = STATUS_HEAD_SLOT;
               end else if (slot_over) begin
                  rsp_status_in = STATUS_BOUNDS;
               end else if (!used_rdata) begin
                  rsp_status_in = STATUS_IS_FREE;
               end else begin
                  used_we       = 1'b1;
                  used_wdata    = 1'b0;
                  link_we       = 1'b1;
                  link_waddr    = slot_ff[SW-1:0];
                  rsp_status_in = STATUS_OK;
                  if (list_short) begin
                     // push to the front
                     link_wdata   = free_head_ff;
                     free_head_in = slot_ff[SW-1:0];
                  end else begin
                     // link in after the first free slot; the head entry is rewritten in the link step
                     link_wdata = link_rdata;
                  end
               end
            end
         end
         ST_LINK: begin
            link_we    = 1'b1;
            link_waddr = free_head_ff;
            link_wdata = slot_ff[SW-1:0];
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= SW'(FILENULL);
         highest_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         highest_ff   <= highest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= opcode_type'(req_tuser);
         slot_ff <= req_slot;
      end
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_slot_ff);
   assign rsp_tuser  = rsp_status_ff;

   `FLS_ASSERT(a_link_after_exec, (state_ff == ST_LINK) |-> ($past(state_ff) == ST_EXEC), "link step without decide step")
   `FLS_ASSERT(a_exec_loads_rsp, (state_ff == ST_EXEC && state_in != ST_EXEC) |=> rsp_valid_ff, "decide step left no response")
   `FLS_ASSERT(a_head_stable, (state_ff != ST_EXEC) |=> $stable(free_head_ff), "free head moved outside decide step")
   `FLS_ASSERT_ANY(a_idle_no_write, (!reset && state_ff == ST_IDLE) |-> (!link_we && !used_we), "memory write while idle")

endmodule

// ===== dv/slot_grant_checker.sv =====
module slot_grant_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [fls_pkg::REQ_DATA_W-1:0]  req_tdata,   // [9:0] slot_index, rest zero
   input  logic                            req_tuser,   // [0] opcode
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [fls_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [9:0] granted_slot, rest zero
   input  logic [fls_pkg::STATUS_W-1:0]    rsp_tuser,   // [2:0] status
   output int                              mismatches,
   output int                              outstanding
);
   import fls_pkg::*;

   localparam int TOP_SLOT   = POOL_SLOTS_DEF - 1;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [RSP_DATA_W-1:0] granted;
      status_type            status;
   } grant_result_type;

   // Shadow copy of the allocator state
   logic [SLOT_W-1:0] free_head;
   logic [SLOT_W-1:0] highest_slot;
   logic [SLOT_W-1:0] next_link [POOL_SLOTS_DEF];
   logic              in_use    [POOL_SLOTS_DEF];

   grant_result_type expected_grants [$];
   grant_result_type oldest_grant;
   int               mismatch_total;

   // Apply one request to the shadow state and return the response it causes
   function automatic grant_result_type allocate_or_free(input opcode_type op,
                                                         input logic [SLOT_W-1:0] slot);
      grant_result_type  res;
      logic [SLOT_W-1:0] first;
      res.granted = '0;
      res.status  = STATUS_OK;
      if (op == OP_ALLOC) begin
         if (free_head == FILENULL) begin
            // empty list: grow the pool by one slot, unless it is exhausted
            if (highest_slot == TOP_SLOT) begin
               res.status = STATUS_FULL;
               return res;
            end
            highest_slot = highest_slot + 1'b1;
            slot         = highest_slot;
         end else begin
            slot      = free_head;
            free_head = next_link[slot];
         end
         next_link[slot] = SLOT_W'(FILENULL);
         in_use[slot]    = 1'b1;
         res.granted     = RSP_DATA_W'(slot);
      end else if (slot == 0) begin
         res.status = STATUS_HEAD_SLOT;
      end else if (slot > highest_slot) begin
         res.status = STATUS_BOUNDS;
      end else if (!in_use[slot]) begin
         res.status = STATUS_IS_FREE;
      end else begin
         // push to the front of a short list, else link in after the first entry
         in_use[slot] = 1'b0;
         first        = free_head;
         if (first == FILENULL || next_link[first] == FILENULL) begin
            next_link[slot] = first;
            free_head       = slot;
         end else begin
            next_link[slot]  = next_link[first];
            next_link[first] = slot;
         end
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string field, input int want, input int got);
      mismatch_total++;
      if (mismatch_total <= REPORT_MAX)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $time, field, want, got);
   endtask

   // Compare responses first so a request accepted on the same edge is not matched
   always @(posedge clock) begin
      if (reset) begin
         free_head    = '0;
         highest_slot = '0;
         expected_grants.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_grants.size() == 0) begin
               flag_mismatch("unrequested response", 0, int'(rsp_tdata));
            end else begin
               oldest_grant = expected_grants.pop_front();
               if (rsp_tdata !== oldest_grant.granted)
                  flag_mismatch("granted_slot", int'(oldest_grant.granted), int'(rsp_tdata));
               if (rsp_tuser !== oldest_grant.status)
                  flag_mismatch("status", int'(oldest_grant.status), int'(rsp_tuser));
            end
         end
         if (req_tvalid && req_tready)
            expected_grants.push_back(allocate_or_free(opcode_type'(req_tuser),
                                                       req_tdata[SLOT_W-1:0]));
      end
      mismatches  <= mismatch_total;
      outstanding <= expected_grants.size();
   end

endmodule

// ===== dv/tb_free_list_slot_allocator_top.sv =====
module tb_free_list_slot_allocator_top;
   import fls_pkg::*;

   localparam int TOP_SLOT       = POOL_SLOTS_DEF - 1;
   localparam int TOTAL_REQUESTS = 1850;
   localparam int GAP_PERCENT    = 10;
   localparam int HOLD_CYCLES    = 200;
   localparam int HOLD_AFTER     = 300;
   localparam int QUIET_FIRST    = 600;
   localparam int QUIET_LAST     = 900;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   int mismatches;
   int outstanding;
   int requests_sent;
   int allocs_sent;
   int responses_seen;
   int idle_cycles;

   always #5 clock = ~clock;

   free_list_slot_allocator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   slot_grant_checker grant_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Count responses and abort when traffic stops moving
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         responses_seen <= responses_seen + 1;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** free_list_slot_allocator_top: FAILED **");
         $finish;
      end
   end

   // Offer one request, with a random gap ahead of it, and hold until accepted
   task automatic send_request(input opcode_type op, input int slot);
      int gap;
      gap = 0;
      if (!(requests_sent >= QUIET_FIRST && requests_sent < QUIET_LAST) &&
          $urandom_range(0, 99) < GAP_PERCENT)
         gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W-SLOT_W){1'b0}}, slot[SLOT_W-1:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      if (op == OP_ALLOC)
         allocs_sent++;
   endtask

   // Drop rsp_tready at random, hold it off once for a long stretch
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && responses_seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= (responses_seen >= QUIET_FIRST && responses_seen < QUIET_LAST) ||
                       ($urandom_range(0, 99) >= GAP_PERCENT);
      end
   end

   initial begin
      int pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Refusals on an empty pool, then grow it
      send_request(OP_FREE, 0);
      send_request(OP_FREE, 1);
      send_request(OP_FREE, TOP_SLOT);
      repeat (5) send_request(OP_ALLOC, $urandom_range(0, TOP_SLOT));
      // free into an empty list, double free, one-entry list, longer list
      send_request(OP_FREE, 3);
      send_request(OP_FREE, 3);
      send_request(OP_FREE, 5);
      send_request(OP_FREE, 2);
      send_request(OP_FREE, 1);
      // pop from the list, refuse bad slots, then grow again once it empties
      send_request(OP_ALLOC, TOP_SLOT);
      send_request(OP_ALLOC, 0);
      send_request(OP_FREE, 6);
      send_request(OP_FREE, TOP_SLOT);
      send_request(OP_FREE, 0);
      send_request(OP_ALLOC, 0);
      send_request(OP_ALLOC, 0);
      send_request(OP_ALLOC, 0);
      send_request(OP_FREE, 4);
      send_request(OP_ALLOC, 0);

      // Mostly allocate until the pool is exhausted and refuses a few times
      while (allocs_sent < TOP_SLOT + 60) begin
         if ($urandom_range(0, 99) < 5)
            send_request(OP_FREE, $urandom_range(0, TOP_SLOT));
         else
            send_request(OP_ALLOC, $urandom_range(0, TOP_SLOT));
      end

      // Churn the full pool: balanced allocate and free, some head-slot noise
      while (requests_sent < TOTAL_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)
            send_request(OP_ALLOC, $urandom_range(0, TOP_SLOT));
         else if (pick < 93)
            send_request(OP_FREE, $urandom_range(1, TOP_SLOT));
         else
            send_request(OP_FREE, 0);
      end
      req_tvalid <= 1'b0;

      // Drain the remaining responses
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("** free_list_slot_allocator_top: PASSED **");
      else
         $display("** free_list_slot_allocator_top: FAILED **");
      $finish;
   end

endmodule

// ===== free_list_slot_allocator_top.f =====
+incdir+hdl
hdl/fls_pkg.sv
hdl/fls_ram.sv
hdl/free_list_slot_allocator_top.sv
dv/slot_grant_checker.sv
dv/tb_free_list_slot_allocator_top.sv
